// ===== sv/bdc_pkg.sv =====
// Shared types, widths and constants of the bearing/distance/correction pipeline.
// Holds the CORDIC arctangent table and the pipeline lane structure.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package bdc_pkg;

  // Coordinate width on the ports (fixed by the field layout).
  localparam int COORD_BITS = 8;
  localparam int HDG_W      = 16;   // heading, bearing and distance width
  localparam int CORR_W     = 17;   // signed correction width

  // CORDIC datapath: x and y start as |d| << FRAC_SH, two guard bits for the
  // gain and one for the sign, rounded up to keep a spare bit.
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int FRAC_SH           = 24;
  localparam int XY_W              = COORD_BITS + FRAC_SH + 4;
  localparam int Z_W               = 26;   // degrees, 16 fraction bits, signed
  localparam int T_W               = 23;   // clamped first-quadrant angle
  localparam int FULL_W            = 25;   // full-circle angle, Q16 degrees

  // Square root of (dx^2 + dy^2) * 2^14, one result bit per stage.
  localparam int DIST_SH    = 14;
  localparam int SQ_W       = 32;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int REM_W      = ROOT_W + 2;

  localparam logic [FULL_W-1:0] DEG90_Q16  = FULL_W'(90 * 65536);
  localparam logic [FULL_W-1:0] DEG180_Q16 = FULL_W'(180 * 65536);
  localparam logic [FULL_W-1:0] DEG360_Q16 = FULL_W'(360 * 65536);
  localparam logic [FULL_W-1:0] BRG_HALF   = FULL_W'(256);
  localparam int                BRG_SHIFT  = 9;

  localparam logic [HDG_W-1:0] FULL_TURN   = HDG_W'(46080);
  localparam logic [HDG_W-1:0] BRG_DEG0    = HDG_W'(0);
  localparam logic [HDG_W-1:0] BRG_DEG90   = HDG_W'(90 * 128);
  localparam logic [HDG_W-1:0] BRG_DEG180  = HDG_W'(180 * 128);
  localparam logic [HDG_W-1:0] BRG_DEG270  = HDG_W'(270 * 128);
  localparam logic [HDG_W-1:0] DIST_MAX    = {HDG_W{1'b1}};

  // One item as it travels through the prep and iteration stages.
  typedef struct packed {
    logic                    valid;
    logic                    dx_neg;
    logic                    dy_neg;
    logic                    dx_zero;
    logic                    dy_zero;
    logic [HDG_W-1:0]        prev;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
    logic [SQ_W-1:0]         sqr;
    logic [REM_W-1:0]        rem;
    logic [ROOT_W-1:0]       root;
  } bdc_lane_t;

  // round(atan(2^-i) * 180/pi * 65536)
  function automatic logic [Z_W-1:0] atan_q16(input int unsigned idx);
    logic [Z_W-1:0] v;
    case (idx)
      0:       v = Z_W'(2949120);
      1:       v = Z_W'(1740967);
      2:       v = Z_W'(919879);
      3:       v = Z_W'(466945);
      4:       v = Z_W'(234379);
      5:       v = Z_W'(117304);
      6:       v = Z_W'(58666);
      7:       v = Z_W'(29335);
      8:       v = Z_W'(14668);
      9:       v = Z_W'(7334);
      10:      v = Z_W'(3667);
      11:      v = Z_W'(1833);
      12:      v = Z_W'(917);
      13:      v = Z_W'(458);
      14:      v = Z_W'(229);
      15:      v = Z_W'(115);
      16:      v = Z_W'(57);
      17:      v = Z_W'(29);
      18:      v = Z_W'(14);
      19:      v = Z_W'(7);
      20:      v = Z_W'(4);
      21:      v = Z_W'(2);
      22:      v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/bdc_prep.sv =====
// Front of the pipeline: signed coordinate differences, magnitudes, squares.
// Two register stages; produces the initial CORDIC and square-root lane.
// Depends on bdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdc_prep (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [bdc_pkg::COORD_BITS-1:0] object_x,
  input  wire logic [bdc_pkg::COORD_BITS-1:0] object_y,
  input  wire logic [bdc_pkg::COORD_BITS-1:0] robot_x,
  input  wire logic [bdc_pkg::COORD_BITS-1:0] robot_y,
  input  wire logic [bdc_pkg::HDG_W-1:0]      previous_heading,
  output bdc_pkg::bdc_lane_t                  lane_o
);

  localparam int CW = bdc_pkg::COORD_BITS;

  // stage 1: differences
  logic          valid1_r;
  logic          dx_neg_r, dy_neg_r, dx_zero_r, dy_zero_r;
  logic [CW-1:0] ax_r, ay_r;
  logic [bdc_pkg::HDG_W-1:0] prev_r;

  logic [CW:0]   dx, dy, ndx, ndy;
  logic [CW-1:0] ax_nxt, ay_nxt;

  always_comb begin
    dx     = {1'b0, object_x} - {1'b0, robot_x};
    dy     = {1'b0, object_y} - {1'b0, robot_y};
    ndx    = -dx;
    ndy    = -dy;
    ax_nxt = dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
    ay_nxt = dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
    end else if (en) begin
      valid1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_neg_r  <= dx[CW];
      dy_neg_r  <= dy[CW];
      dx_zero_r <= (dx == '0);
      dy_zero_r <= (dy == '0);
      ax_r      <= ax_nxt;
      ay_r      <= ay_nxt;
      prev_r    <= previous_heading;
    end
  end

  // stage 2: squares and CORDIC seed
  logic [2*CW-1:0]   ax_sq, ay_sq;
  logic [2*CW:0]     sum_sq;
  bdc_pkg::bdc_lane_t lane_nxt, lane_r;

  always_comb begin
    ax_sq            = ax_r * ax_r;
    ay_sq            = ay_r * ay_r;
    sum_sq           = {1'b0, ax_sq} + {1'b0, ay_sq};
    lane_nxt.valid   = valid1_r;
    lane_nxt.dx_neg  = dx_neg_r;
    lane_nxt.dy_neg  = dy_neg_r;
    lane_nxt.dx_zero = dx_zero_r;
    lane_nxt.dy_zero = dy_zero_r;
    lane_nxt.prev    = prev_r;
    lane_nxt.x       = bdc_pkg::XY_W'({ax_r, {bdc_pkg::FRAC_SH{1'b0}}});
    lane_nxt.y       = bdc_pkg::XY_W'({ay_r, {bdc_pkg::FRAC_SH{1'b0}}});
    lane_nxt.z       = '0;
    lane_nxt.sqr     = bdc_pkg::SQ_W'({sum_sq, {bdc_pkg::DIST_SH{1'b0}}});
    lane_nxt.rem     = '0;
    lane_nxt.root    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

`default_nettype wire

// ===== sv/bdc_iter.sv =====
// One iteration stage: a vectoring CORDIC rotation and one square-root digit.
// Either step can be switched off by parameter; the lane is then only delayed.
// Depends on bdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdc_iter #(
  parameter int unsigned STEP      = 0,
  parameter bit          CORDIC_ON = 1'b1,
  parameter bit          SQRT_ON   = 1'b1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  bdc_pkg::bdc_lane_t lane_i,
  output bdc_pkg::bdc_lane_t lane_o
);

  localparam int XW = bdc_pkg::XY_W;
  localparam int ZW = bdc_pkg::Z_W;
  localparam int RW = bdc_pkg::REM_W;
  localparam int NW = bdc_pkg::ROOT_W;
  localparam int QW = bdc_pkg::SQ_W;

  logic signed [XW-1:0] x_c, y_c, xs, ys;
  logic signed [ZW-1:0] z_c, atan_v;
  logic [RW-1:0]        rem_sh, trial;
  logic                 ge;
  bdc_pkg::bdc_lane_t   lane_nxt, lane_r;

  always_comb begin
    x_c    = lane_i.x;
    y_c    = lane_i.y;
    z_c    = lane_i.z;
    xs     = x_c >>> STEP;
    ys     = y_c >>> STEP;
    atan_v = bdc_pkg::atan_q16(STEP);
    rem_sh = {lane_i.rem[RW-3:0], lane_i.sqr[QW-1 -: 2]};
    trial  = {lane_i.root, 2'b01};
    ge     = (rem_sh >= trial);

    lane_nxt = lane_i;
    if (CORDIC_ON) begin
      // rotate toward the x axis; y sign picks the direction
      if (!y_c[XW-1]) begin
        lane_nxt.x = x_c + ys;
        lane_nxt.y = y_c - xs;
        lane_nxt.z = z_c + atan_v;
      end else begin
        lane_nxt.x = x_c - ys;
        lane_nxt.y = y_c + xs;
        lane_nxt.z = z_c - atan_v;
      end
    end
    if (SQRT_ON) begin
      lane_nxt.sqr  = lane_i.sqr << 2;
      lane_nxt.rem  = ge ? (rem_sh - trial) : rem_sh;
      lane_nxt.root = {lane_i.root[NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

`default_nettype wire

// ===== sv/bdc_finish.sv =====
// Back of the pipeline: quadrant mapping, rounding and wrap of the bearing,
// distance rounding, and the heading correction. Three register stages.
// Depends on bdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdc_finish (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  bdc_pkg::bdc_lane_t                      lane_i,
  output logic                                    valid_o,
  output logic [bdc_pkg::HDG_W-1:0]               bearing_o,
  output logic [bdc_pkg::HDG_W-1:0]               distance_o,
  output logic signed [bdc_pkg::CORR_W-1:0]       correction_o
);

  localparam int HW = bdc_pkg::HDG_W;
  localparam int FW = bdc_pkg::FULL_W;
  localparam int TW = bdc_pkg::T_W;
  localparam int NW = bdc_pkg::ROOT_W;
  localparam int CW = bdc_pkg::CORR_W;

  // stage 1: clamp, quadrant map, distance rounding
  logic signed [bdc_pkg::Z_W-1:0] z_c;
  logic [TW-1:0] t;
  logic [FW-1:0] full_nxt;
  logic          spec_nxt;
  logic [HW-1:0] spec_brg_nxt;
  logic [NW:0]   dist_rnd;
  logic [HW-1:0] dist_nxt;

  always_comb begin
    z_c = lane_i.z;
    priority if (z_c[bdc_pkg::Z_W-1]) begin
      t = '0;
    end else if (z_c > $signed({1'b0, bdc_pkg::DEG90_Q16})) begin
      t = bdc_pkg::DEG90_Q16[TW-1:0];
    end else begin
      t = z_c[TW-1:0];
    end

    priority if (!lane_i.dx_neg && !lane_i.dy_neg) begin
      full_nxt = FW'(t);
    end else if (lane_i.dx_neg && !lane_i.dy_neg) begin
      full_nxt = bdc_pkg::DEG180_Q16 - FW'(t);
    end else if (lane_i.dx_neg) begin
      full_nxt = bdc_pkg::DEG180_Q16 + FW'(t);
    end else begin
      full_nxt = bdc_pkg::DEG360_Q16 - FW'(t);
    end

    // points on an axis, or coincident, bypass the CORDIC angle
    spec_nxt = lane_i.dx_zero || lane_i.dy_zero;
    priority if (lane_i.dx_zero && lane_i.dy_zero) begin
      spec_brg_nxt = bdc_pkg::BRG_DEG0;
    end else if (lane_i.dy_zero) begin
      spec_brg_nxt = lane_i.dx_neg ? bdc_pkg::BRG_DEG180 : bdc_pkg::BRG_DEG0;
    end else begin
      spec_brg_nxt = lane_i.dy_neg ? bdc_pkg::BRG_DEG270 : bdc_pkg::BRG_DEG90;
    end

    // round to nearest: bump when remainder exceeds the floor root
    dist_rnd = {1'b0, lane_i.root} +
               (NW+1)'(lane_i.rem > bdc_pkg::REM_W'(lane_i.root));
    dist_nxt = (dist_rnd > (NW+1)'(bdc_pkg::DIST_MAX)) ? bdc_pkg::DIST_MAX
                                                         : dist_rnd[HW-1:0];
  end

  logic          v1_r, spec1_r;
  logic [FW-1:0] full1_r;
  logic [HW-1:0] spec_brg1_r, dist1_r, prev1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= lane_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spec1_r     <= spec_nxt;
      full1_r     <= full_nxt;
      spec_brg1_r <= spec_brg_nxt;
      dist1_r     <= dist_nxt;
      prev1_r     <= lane_i.prev;
    end
  end

  // stage 2: round to 1/128 degree, wrap a full turn to zero
  logic [FW-1:0] full_rnd;
  logic [HW-1:0] brg_q, brg_nxt;

  always_comb begin
    full_rnd = full1_r + bdc_pkg::BRG_HALF;
    brg_q    = full_rnd[bdc_pkg::BRG_SHIFT +: HW];
    priority if (spec1_r) begin
      brg_nxt = spec_brg1_r;
    end else if (brg_q >= bdc_pkg::FULL_TURN) begin
      brg_nxt = bdc_pkg::BRG_DEG0;
    end else begin
      brg_nxt = brg_q;
    end
  end

  logic          v2_r;
  logic [HW-1:0] brg2_r, dist2_r, prev2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      brg2_r  <= brg_nxt;
      dist2_r <= dist1_r;
      prev2_r <= prev1_r;
    end
  end

  // stage 3: correction = -|bearing - previous heading|
  logic signed [CW-1:0] diff, corr_nxt;

  always_comb begin
    diff     = $signed({1'b0, brg2_r}) - $signed({1'b0, prev2_r});
    corr_nxt = (diff > 0) ? -diff : diff;
  end

  logic                 v3_r;
  logic [HW-1:0]        brg3_r, dist3_r;
  logic signed [CW-1:0] corr3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      brg3_r  <= brg2_r;
      dist3_r <= dist2_r;
      corr3_r <= corr_nxt;
    end
  end

  assign valid_o      = v3_r;
  assign bearing_o    = brg3_r;
  assign distance_o   = dist3_r;
  assign correction_o = corr3_r;

endmodule

`default_nettype wire

// ===== sv/bearing_distance_correction.sv =====
// Top level of the bearing / distance / heading-correction pipeline.
// Instantiates bdc_prep, a chain of bdc_iter stages and bdc_finish; uses bdc_pkg.
//
// Takes an object and a robot grid position plus an earlier heading and returns
// the bearing from robot to object (1/128 degree, counterclockwise from +x, in
// [0, 360)), the rounded Euclidean distance (1/128 grid unit) and the heading
// correction -|bearing - previous_heading| (no wrap at 360). The bearing comes
// from a vectoring CORDIC on |dx|, |dy| mapped to its quadrant; points on an
// axis give exact multiples of 90 degrees and coincident points give bearing 0
// and distance 0. The distance comes from a digit-by-digit square root that
// runs in the same stages as the CORDIC, one result bit per stage. The block
// takes one beat per clock unless the output stalls, and returns one beat per
// input beat, in order. Each beat passes through bdc_prep, the bdc_iter chain
// and bdc_finish. The whole pipeline holds as one when a finished beat waits at
// the output, so in_tready follows !out_tvalid || out_tready; bubbles in flight
// do not let new beats in early.
`timescale 1ns / 1ps
`default_nettype none

module bearing_distance_correction #(
  parameter int unsigned CORDIC_STAGES = bdc_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input beat
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] object_x, [15:8] object_y, [23:16] robot_x, [31:24] robot_y,
  // [47:32] previous_heading
  input  wire logic [47:0] in_tdata,
  // result beat
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] bearing, [31:16] distance, [48:32] correction (signed),
  // [55:49] zero
  output logic [55:0]      out_tdata
);

  localparam int CB       = bdc_pkg::COORD_BITS;
  localparam int HW       = bdc_pkg::HDG_W;
  localparam int CW       = bdc_pkg::CORR_W;
  localparam int NUM_ITER = (CORDIC_STAGES > bdc_pkg::SQRT_STEPS) ?
                            CORDIC_STAGES : bdc_pkg::SQRT_STEPS;

  // global advance: hold every stage while the output beat is not taken
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  bdc_pkg::bdc_lane_t lane [NUM_ITER+1];

  bdc_prep u_prep (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (adv),
    .in_valid         (in_tvalid),
    .object_x         (in_tdata[CB-1:0]),
    .object_y         (in_tdata[2*CB-1:CB]),
    .robot_x          (in_tdata[3*CB-1:2*CB]),
    .robot_y          (in_tdata[4*CB-1:3*CB]),
    .previous_heading (in_tdata[4*CB+HW-1:4*CB]),
    .lane_o           (lane[0])
  );

  for (genvar gi = 0; gi < NUM_ITER; gi++) begin : g_iter
    bdc_iter #(
      .STEP      (gi),
      .CORDIC_ON (gi < CORDIC_STAGES),
      .SQRT_ON   (gi < bdc_pkg::SQRT_STEPS)
    ) u_iter (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .lane_i (lane[gi]),
      .lane_o (lane[gi+1])
    );
  end

  logic                 fin_valid;
  logic [HW-1:0]        bearing, distance;
  logic signed [CW-1:0] correction;

  bdc_finish u_finish (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .lane_i       (lane[NUM_ITER]),
    .valid_o      (fin_valid),
    .bearing_o    (bearing),
    .distance_o   (distance),
    .correction_o (correction)
  );

  assign out_tvalid = fin_valid;
  assign out_tdata  = {{(56-2*HW-CW){1'b0}}, correction, distance, bearing};

  // bearing always lands inside one turn
  a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (bearing < bdc_pkg::FULL_TURN))
    else $error("bearing beyond a full turn");

  // correction is never positive
  a_corr_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (correction[CW-1] || (correction == '0)))
    else $error("positive heading correction");

  // square-root remainder stays within 2*root after the last digit
  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    lane[NUM_ITER].valid |->
      (lane[NUM_ITER].rem <= {1'b0, lane[NUM_ITER].root, 1'b0}))
    else $error("square-root remainder out of range");

  // coincident points leave the square-root chain with a zero root
  a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (lane[NUM_ITER].valid && lane[NUM_ITER].dx_zero && lane[NUM_ITER].dy_zero)
      |-> (lane[NUM_ITER].root == '0))
    else $error("nonzero distance for coincident points");

endmodule

`default_nettype wire

// ===== sim/bearing_distance_correction_test.sv =====
// Self-checking testbench for bearing_distance_correction: a directed table, then random beats,
// all under bursty input and patterned output stalls, checked against a CORDIC/sqrt predictor.
// Depends on bdc_pkg and the bearing_distance_correction RTL only.
`timescale 1ns / 1ps

module bearing_distance_correction_test;

  localparam int LATENCY      = 21;
  localparam int RANDOM_BEATS = 1300;
  localparam int LONG_HOLD    = 400;
  localparam int IDLE_LIMIT   = 2000;

  localparam int     STAGES    = bdc_pkg::CORDIC_STAGES_DEF;
  localparam longint Q16_DEG90 = 90 * 65536;
  localparam longint TURN_128  = 46080;
  localparam longint ATAN_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // Input beat, last field in the lowest bits.
  typedef struct packed {
    logic [bdc_pkg::HDG_W-1:0] heading;
    logic [7:0]                rob_y;
    logic [7:0]                rob_x;
    logic [7:0]                obj_y;
    logic [7:0]                obj_x;
  } fix_req_t;

  // Result beat, last field in the lowest bits.
  typedef struct packed {
    logic [6:0]                         pad;
    logic signed [bdc_pkg::CORR_W-1:0]  correction;
    logic [bdc_pkg::HDG_W-1:0]          distance;
    logic [bdc_pkg::HDG_W-1:0]          bearing;
  } fix_res_t;

  // Directed row: inputs, then an optional hand-written result.
  typedef struct packed {
    logic [7:0]         ox;
    logic [7:0]         oy;
    logic [7:0]         rx;
    logic [7:0]         ry;
    logic [15:0]        hdg;
    logic               known;
    logic [15:0]        brg;
    logic [15:0]        reach;
    logic signed [16:0] corr;
  } fix_row_t;

  typedef enum int {SHAPE_COINCIDENT, SHAPE_AXIS, SHAPE_NEAR, SHAPE_SPREAD} shape_e;
  typedef enum int {HDG_ANY, HDG_RANGE, HDG_MATCH} heading_mode_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  localparam fix_row_t DIRECTED [24] = '{
    // coincident points at both corners of the grid
    '{8'd0,   8'd0,   8'd0,   8'd0,   16'd0,     1'b1, bdc_pkg::BRG_DEG0,   16'd0,     17'sd0},
    '{8'd255, 8'd255, 8'd255, 8'd255, 16'd46079, 1'b1, bdc_pkg::BRG_DEG0,   16'd0,     -17'sd46079},
    // the four axis directions at full reach
    '{8'd255, 8'd0,   8'd0,   8'd0,   16'd0,     1'b1, bdc_pkg::BRG_DEG0,   16'd32640, 17'sd0},
    '{8'd0,   8'd7,   8'd255, 8'd7,   16'd23040, 1'b1, bdc_pkg::BRG_DEG180, 16'd32640, 17'sd0},
    '{8'd9,   8'd255, 8'd9,   8'd0,   16'd0,     1'b1, bdc_pkg::BRG_DEG90,  16'd32640, -17'sd11520},
    '{8'd0,   8'd0,   8'd0,   8'd255, 16'd65535, 1'b1, bdc_pkg::BRG_DEG270, 16'd32640, -17'sd30975},
    // heading far above the bearing range, and a zero heading against 270 degrees
    '{8'd1,   8'd0,   8'd0,   8'd0,   16'd65535, 1'b1, bdc_pkg::BRG_DEG0,   16'd128,   -17'sd65535},
    '{8'd100, 8'd50,  8'd100, 8'd150, 16'd0,     1'b1, bdc_pkg::BRG_DEG270, 16'd12800, -17'sd34560},
    '{8'd0,   8'd0,   8'd0,   8'd0,   16'd65535, 1'b1, bdc_pkg::BRG_DEG0,   16'd0,     -17'sd65535},
    // off-axis points go through the predictor
    '{8'd3,   8'd4,   8'd0,   8'd0,   16'd0,     1'b0, 16'd0, 16'd0, 17'sd0},
    '{8'd255, 8'd255, 8'd0,   8'd0,   16'd0,     1'b0, 16'd0, 16'd0, 17'sd0},
    '{8'd0,   8'd255, 8'd255, 8'd0,   16'd46079, 1'b0, 16'd0, 16'd0, 17'sd0},
    '{8'd0,   8'd0,   8'd255, 8'd255, 16'd65535, 1'b0, 16'd0, 16'd0, 17'sd0},
    '{8'd255, 8'd0,   8'd0,   8'd255, 16'd0,     1'b0, 16'd0, 16'd0, 17'sd0},
    '{8'd1,   8'd1,   8'd0,   8'd0,   16'd5760,  1'b0, 16'd0, 16'd0, 17'sd0},
    '{8'd0,   8'd1,   8'd1,   8'd0,   16'd17280, 1'b0, 16'd0, 16'd0, 17'sd0},
    '{8'd0,   8'd0,   8'd1,   8'd1,   16'd28800, 1'b0, 16'd0, 16'd0, 17'sd0},
    '{8'd1,   8'd0,   8'd0,   8'd1,   16'd40320, 1'b0, 16'd0, 16'd0, 17'sd0},
    // just off an axis, including just below a full turn, then other off-axis points
    '{8'd255, 8'd1,   8'd0,   8'd0,   16'd0,     1'b0, 16'd0, 16'd0, 17'sd0},
    '{8'd255, 8'd0,   8'd0,   8'd1,   16'd46079, 1'b0, 16'd0, 16'd0, 17'sd0},
    '{8'd1,   8'd255, 8'd0,   8'd0,   16'd11520, 1'b0, 16'd0, 16'd0, 17'sd0},
    '{8'd128, 8'd128, 8'd127, 8'd127, 16'd32768, 1'b0, 16'd0, 16'd0, 17'sd0},
    '{8'd200, 8'd10,  8'd10,  8'd200, 16'd65535, 1'b0, 16'd0, 16'd0, 17'sd0},
    '{8'd17,  8'd33,  8'd200, 8'd99,  16'd46079, 1'b0, 16'd0, 16'd0, 17'sd0}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  fix_res_t queued_fix_q[$];   // driven, not yet accepted
  fix_res_t awaited_fix_q[$];  // accepted, result not yet seen
  int       errors        = 0;
  int       result_beats  = 0;
  int       idle_cycles   = 0;
  bit       long_hold_req = 1'b0;

  bearing_distance_correction u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #2 clk = ~clk;

  // First-quadrant angle of (ax, ay) by vectoring CORDIC, degrees in Q16, clamped to [0, 90].
  function automatic longint cordic_quadrant_q16(input longint ax, input longint ay);
    longint x, y, z, xs, ys;
    x = ax <<< 24;
    y = ay <<< 24;
    z = 0;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_Q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_Q16[i];
      end
    end
    if (z < 0) z = 0;
    if (z > Q16_DEG90) z = Q16_DEG90;
    return z;
  endfunction

  // Square root rounded to nearest, saturated to 16 bits.
  function automatic logic [15:0] rounded_root(input longint unsigned v);
    longint unsigned rem, res, b;
    rem = v;
    res = 0;
    b   = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    if (v > res * res + res) res = res + 1;
    return (res > 64'hFFFF) ? 16'hFFFF : res[15:0];
  endfunction

  function automatic fix_res_t predict_fix(input fix_req_t r);
    longint   dx, dy, ax, ay, t, full, brg, diff;
    fix_res_t res;
    dx = longint'(r.obj_x) - longint'(r.rob_x);
    dy = longint'(r.obj_y) - longint'(r.rob_y);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (dx == 0 && dy == 0) begin
      brg = 0;
    end else if (dy == 0) begin
      brg = (dx > 0) ? 0 : 180 * 128;
    end else if (dx == 0) begin
      brg = (dy > 0) ? 90 * 128 : 270 * 128;
    end else begin
      t = cordic_quadrant_q16(ax, ay);
      if (dx > 0 && dy > 0)     full = t;
      else if (dx < 0 && dy > 0) full = 2 * Q16_DEG90 - t;
      else if (dx < 0)          full = 2 * Q16_DEG90 + t;
      else                      full = 4 * Q16_DEG90 - t;
      brg = (full + 256) >>> 9;
      if (brg >= TURN_128) brg = 0;
    end
    diff = brg - longint'(r.heading);
    if (diff > 0) diff = -diff;
    res            = '0;
    res.bearing    = brg[15:0];
    res.distance   = rounded_root(longint'((ax * ax + ay * ay) * 16384));
    res.correction = diff[16:0];
    return res;
  endfunction

  function automatic fix_req_t random_fix_req();
    fix_req_t      r;
    fix_res_t      p;
    int            pick;
    shape_e        shape;
    heading_mode_e hmode;
    r.obj_x = 8'($urandom_range(0, 255));
    r.obj_y = 8'($urandom_range(0, 255));
    r.rob_x = 8'($urandom_range(0, 255));
    r.rob_y = 8'($urandom_range(0, 255));
    pick  = $urandom_range(0, 9);
    shape = (pick < 3) ? shape_e'(pick) : SHAPE_SPREAD;
    case (shape)
      SHAPE_COINCIDENT: begin
        r.rob_x = r.obj_x;
        r.rob_y = r.obj_y;
      end
      SHAPE_AXIS: begin
        if ($urandom_range(0, 1) != 0) r.rob_x = r.obj_x;
        else r.rob_y = r.obj_y;
      end
      SHAPE_NEAR: begin
        r.rob_x = r.obj_x + 8'($urandom_range(0, 6)) - 8'd3;
        r.rob_y = r.obj_y + 8'($urandom_range(0, 6)) - 8'd3;
      end
      default: ;
    endcase
    hmode = heading_mode_e'($urandom_range(0, 2));
    case (hmode)
      HDG_ANY:   r.heading = 16'($urandom_range(0, 65535));
      HDG_RANGE: r.heading = 16'($urandom_range(0, 46079));
      default: begin
        // land on or next to the new bearing so the correction runs through zero
        r.heading = '0;
        p = predict_fix(r);
        r.heading = p.bearing + 16'($urandom_range(0, 2)) - 16'd1;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH beat %0d %s: got %0d, want %0d", result_beats, what, got, want);
    errors++;
  endtask

  // Offer one beat; open a new burst after a random gap when the current one runs out.
  task automatic offer_beat(input fix_req_t req, input fix_res_t want, inout int burst_left);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
    queued_fix_q.push_back(want);
    in_tvalid <= 1'b1;
    in_tdata  <= req;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  // Drop valid and hold until every accepted beat has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (awaited_fix_q.size() != 0 || queued_fix_q.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    fix_req_t req;
    fix_res_t want;
    int       burst_left;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      req = '{DIRECTED[i].hdg, DIRECTED[i].ry, DIRECTED[i].rx, DIRECTED[i].oy, DIRECTED[i].ox};
      if (DIRECTED[i].known) want = '{7'd0, DIRECTED[i].corr, DIRECTED[i].reach, DIRECTED[i].brg};
      else want = predict_fix(req);
      offer_beat(req, want, burst_left);
    end
    drain_results();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      // ask for a long output stall while beats keep coming, later let the pipe empty
      if (n == 300) long_hold_req = 1'b1;
      if (n == 800) drain_results();
      req = random_fix_req();
      offer_beat(req, predict_fix(req), burst_left);
    end
    drain_results();
    repeat (2 * LATENCY) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Output stalls: segments of random length, each with its own pattern.
  initial begin : result_stalls
    int       span;
    rx_mode_e mode;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      span = $urandom_range(16, 160);
      mode = rx_mode_e'($urandom_range(0, 3));
      for (int c = 0; c < span; c++) begin
        case (mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:   out_tready <= ((c % 5) != 4);
        endcase
        @(posedge clk);
      end
    end
  end

  // Move expectations on input handshakes; compare on output handshakes.
  always @(posedge clk) begin : check_results
    fix_res_t got;
    fix_res_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready && queued_fix_q.size() != 0)
        awaited_fix_q.push_back(queued_fix_q.pop_front());
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (awaited_fix_q.size() == 0) begin
          report_mismatch("result beat with nothing awaited", got.bearing, 0);
        end else begin
          want = awaited_fix_q.pop_front();
          if (got.bearing != want.bearing)
            report_mismatch("bearing", got.bearing, want.bearing);
          if (got.distance != want.distance)
            report_mismatch("distance", got.distance, want.distance);
          if (got.correction != want.correction)
            report_mismatch("correction", got.correction, want.correction);
          if (got.pad != want.pad)
            report_mismatch("pad bits", got.pad, want.pad);
        end
        result_beats++;
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TIMEOUT after %0d idle cycles", idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule
